// ===== rtl/drl_pkg.sv =====
`timescale 1ns / 1ps

package drl_pkg;

	localparam int DIR_SIZE_W = 16;
	localparam int MAX_ROWS_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [0:0] REG_DIR_SIZE = 1'd0;
	localparam logic [0:0] REG_MAX_ROWS = 1'd1;

	localparam logic [DIR_SIZE_W-1:0] DIR_SIZE_RST = 16'd0;
	localparam logic [MAX_ROWS_W-1:0] MAX_ROWS_RST = 8'd255;

	localparam logic [15:0] OFS_INODE_0 = 16'd0;
	localparam logic [15:0] OFS_INODE_1 = 16'd1;
	localparam logic [15:0] OFS_INODE_2 = 16'd2;
	localparam logic [15:0] OFS_INODE_3 = 16'd3;
	localparam logic [15:0] OFS_LEN_LO  = 16'd4;
	localparam logic [15:0] OFS_LEN_HI  = 16'd5;
	localparam logic [15:0] OFS_NAME_LEN = 16'd6;
	localparam logic [15:0] OFS_TYPE    = 16'd7;
	localparam logic [15:0] OFS_NAME    = 16'd8;
	localparam logic [15:0] MIN_REC_LEN = 16'd8;

	typedef struct packed {
		logic [15:0] byte_offset;
		logic [15:0] record_start;
		logic [15:0] record_length;
		logic [31:0] inode_gather;
		logic [7:0]  name_length;
		logic [7:0]  rows_emitted;
		logic        finished;
	} state_t;

	typedef struct packed {
		logic [7:0]  row_index;
		logic [31:0] entry_inode;
		logic [7:0]  name_byte;
		logic        byte_valid;
		logic        row_end;
		logic        done_res;
		logic        ok;
	} res_t;

	localparam state_t STATE_RST = '{
		byte_offset:   16'd0,
		record_start:  16'd0,
		record_length: 16'd0,
		inode_gather:  32'd0,
		name_length:   8'd0,
		rows_emitted:  8'd0,
		finished:      1'b1
	};

endpackage

// ===== rtl/drl_step.sv =====
`timescale 1ns / 1ps

module drl_step (
	input  drl_pkg::state_t          cur,
	input  logic [7:0]               data_byte,
	input  logic                     first,
	input  logic [15:0]              dir_size,
	input  logic [7:0]               max_rows,
	output drl_pkg::state_t          nxt,
	output logic                     emit,
	output drl_pkg::res_t            res
);
	import drl_pkg::*;

	state_t      st;
	logic [15:0] rel;
	logic [15:0] rec_len_new;
	logic        last;
	logic        row_done;
	logic        advance;

	always_comb begin
		st = cur;
		if (first) begin
			st = '0;
		end
		nxt = st;
		emit = 1'b0;
		res = '0;
		advance = 1'b0;
		rel = st.byte_offset;
		rec_len_new = {data_byte, st.record_length[7:0]};
		last = ({1'b0, st.record_start} + {1'b0, st.record_length}) >= {1'b0, dir_size};
		row_done = (rel == (OFS_TYPE + {8'd0, st.name_length}));
		if (first || !cur.finished) begin
			advance = 1'b1;
			priority if (rel == OFS_INODE_0) begin
				nxt.inode_gather = {24'd0, data_byte};
				priority if (st.record_start >= dir_size) begin
					emit = 1'b1;
					res.row_index = st.rows_emitted;
					res.done_res = 1'b1;
					res.ok = 1'b1;
					nxt.finished = 1'b1;
					advance = 1'b0;
				end else if (st.rows_emitted >= max_rows) begin
					emit = 1'b1;
					res.row_index = st.rows_emitted;
					res.done_res = 1'b1;
					nxt.finished = 1'b1;
					advance = 1'b0;
				end else begin
				end
			end else if (rel == OFS_INODE_1) begin
				nxt.inode_gather[15:8] = data_byte;
			end else if (rel == OFS_INODE_2) begin
				nxt.inode_gather[23:16] = data_byte;
			end else if (rel == OFS_INODE_3) begin
				nxt.inode_gather[31:24] = data_byte;
			end else if (rel == OFS_LEN_LO) begin
				nxt.record_length = {8'd0, data_byte};
			end else if (rel == OFS_LEN_HI) begin
				nxt.record_length = rec_len_new;
				if (rec_len_new < MIN_REC_LEN) begin
					emit = 1'b1;
					res.row_index = st.rows_emitted;
					res.done_res = 1'b1;
					nxt.finished = 1'b1;
					advance = 1'b0;
				end
			end else if (rel == OFS_NAME_LEN) begin
				nxt.name_length = data_byte;
				if ((OFS_NAME + {8'd0, data_byte}) > st.record_length) begin
					emit = 1'b1;
					res.row_index = st.rows_emitted;
					res.done_res = 1'b1;
					nxt.finished = 1'b1;
					advance = 1'b0;
				end
			end else if (rel == OFS_TYPE) begin
				priority if (st.inode_gather == 32'd0) begin
					if (last) begin
						emit = 1'b1;
						res.row_index = st.rows_emitted;
						res.done_res = 1'b1;
						res.ok = 1'b1;
						nxt.finished = 1'b1;
						advance = 1'b0;
					end
				end else if (st.name_length == 8'd0) begin
					emit = 1'b1;
					res.row_index = st.rows_emitted;
					res.entry_inode = st.inode_gather;
					res.row_end = 1'b1;
					res.done_res = last;
					res.ok = last;
					nxt.rows_emitted = st.rows_emitted + 8'd1;
					if (last) begin
						nxt.finished = 1'b1;
						advance = 1'b0;
					end
				end else begin
				end
			end else begin
				if (st.inode_gather != 32'd0 &&
				    {1'b0, rel} < ({1'b0, OFS_NAME} + {9'd0, st.name_length})) begin
					emit = 1'b1;
					res.row_index = st.rows_emitted;
					res.entry_inode = st.inode_gather;
					res.name_byte = data_byte;
					res.byte_valid = 1'b1;
					res.row_end = row_done;
					res.done_res = row_done && last;
					res.ok = row_done && last;
					if (row_done) begin
						nxt.rows_emitted = st.rows_emitted + 8'd1;
					end
					if (row_done && last) begin
						nxt.finished = 1'b1;
						advance = 1'b0;
					end
				end
			end
		end
		if (advance) begin
			if (rel >= OFS_TYPE && ({1'b0, rel} + 17'd1) == {1'b0, st.record_length}) begin
				nxt.record_start = st.record_start + st.record_length;
				nxt.byte_offset = 16'd0;
			end else begin
				nxt.byte_offset = rel + 16'd1;
			end
		end
	end

endmodule

// ===== rtl/directory_record_lister.sv =====
`timescale 1ns / 1ps

// Streaming ext2 directory lister. Feed directory bytes in offset order, one
// transaction per byte, with first set on the byte at offset 0. Each live
// record gives one result per name byte (or one empty result for an empty
// name), tagged with its row number and inode; row_end marks a row's last
// result; done_res closes the listing, and ok marks a clean end. Bytes after
// the end, or without a starting first, are dropped. One byte is taken every
// cycle; each byte is held in the input register, and the per-byte field
// tracking step writes the result register once the output is free. The
// input stalls only while a result waits on a stalled output. dir_size and
// max_rows are written through cfg_we, cfg_index (0 dir_size, 1 max_rows)
// and cfg_data; the user must write them only while no byte is in flight,
// as the block itself does not enforce it.
module directory_record_lister (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [0:0]                      cfg_index,
	input  logic [drl_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            first,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      row_index,
	output logic [31:0]                     entry_inode,
	output logic [7:0]                      name_byte,
	output logic                            byte_valid,
	output logic                            row_end,
	output logic                            done_res,
	output logic                            ok
);
	import drl_pkg::*;

	logic [DIR_SIZE_W-1:0] dir_size_q;
	logic [MAX_ROWS_W-1:0] max_rows_q;
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  first_s1;
	state_t                state_q;
	state_t                state_nxt;
	logic                  step_emit;
	res_t                  step_res;
	logic                  out_valid_q;
	res_t                  res_q;
	logic                  out_free;
	logic                  go;

	assign out_free = !out_valid_q || !out_stall;
	assign go = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_size_q <= DIR_SIZE_RST;
			max_rows_q <= MAX_ROWS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIR_SIZE: dir_size_q <= cfg_data[DIR_SIZE_W-1:0];
				REG_MAX_ROWS: max_rows_q <= cfg_data[MAX_ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			first_s1 <= first;
		end
	end

	drl_step u_step (
		.cur       (state_q),
		.data_byte (byte_s1),
		.first     (first_s1),
		.dir_size  (dir_size_q),
		.max_rows  (max_rows_q),
		.nxt       (state_nxt),
		.emit      (step_emit),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				out_valid_q <= go && step_emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && step_emit) begin
			res_q <= step_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign row_index   = res_q.row_index;
	assign entry_inode = res_q.entry_inode;
	assign name_byte   = res_q.name_byte;
	assign byte_valid  = res_q.byte_valid;
	assign row_end     = res_q.row_end;
	assign done_res    = res_q.done_res;
	assign ok          = res_q.ok;

	a_done_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done_res |-> state_q.finished)
		else $error("done result without finished listing");

	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.ok |-> res_q.done_res)
		else $error("ok set on a result that is not done");

	a_row_has_inode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.done_res |-> res_q.entry_inode != 32'd0)
		else $error("row result from a dead record");

	a_offset_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.byte_offset >= OFS_NAME |-> state_q.byte_offset < state_q.record_length)
		else $error("byte offset past record length");

endmodule

// ===== test/tb_directory_record_lister.sv =====
`timescale 1ns / 1ps

module tb_directory_record_lister;
	import drl_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
	} dir_item_t;

	typedef enum int {
		LIST_CLEAN,
		LIST_SHORT_REC,
		LIST_LONG_NAME,
		LIST_CUT,
		LIST_NOISE
	} listing_kind_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_DIR_SIZE;
	logic [15:0] cfg_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        first = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  row_index;
	logic [31:0] entry_inode;
	logic [7:0]  name_byte;
	logic        byte_valid;
	logic        row_end;
	logic        done_res;
	logic        ok;

	dir_item_t byte_q[$];
	res_t      listing_q[$];
	dir_item_t nxt_item;
	res_t      want;

	logic [15:0] size_lim = DIR_SIZE_RST;
	logic [7:0]  row_lim = MAX_ROWS_RST;
	logic [15:0] cur_ofs = 16'd0;
	logic [15:0] rec_base = 16'd0;
	logic [15:0] rec_len = 16'd0;
	logic [31:0] ino_acc = 32'd0;
	logic [7:0]  nm_len = 8'd0;
	logic [7:0]  row_cnt = 8'd0;
	logic        halted = 1'b1;

	int  fail_cnt = 0;
	int  res_cnt = 0;
	int  queued_cnt = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	bit  tx_burst = 1'b0;
	bit  rx_burst = 1'b0;

	directory_record_lister DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.first      (first),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_index  (row_index),
		.entry_inode(entry_inode),
		.name_byte  (name_byte),
		.byte_valid (byte_valid),
		.row_end    (row_end),
		.done_res   (done_res),
		.ok         (ok)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit final_rec();
		return int'(rec_base) + int'(rec_len) >= int'(size_lim);
	endfunction

	function automatic void step_listing(input logic [7:0] b, input logic lead);
		res_t r;
		bit   emit;
		bit   halt_now;
		r = '0;
		emit = 1'b0;
		halt_now = 1'b0;
		if (lead) begin
			cur_ofs = 16'd0;
			rec_base = 16'd0;
			rec_len = 16'd0;
			ino_acc = 32'd0;
			nm_len = 8'd0;
			row_cnt = 8'd0;
			halted = 1'b0;
		end else if (halted) begin
			return;
		end
		r.row_index = row_cnt;
		if (cur_ofs == OFS_INODE_0) begin
			ino_acc = {24'd0, b};
			if (rec_base >= size_lim) begin
				emit = 1'b1;
				halt_now = 1'b1;
				r.done_res = 1'b1;
				r.ok = 1'b1;
			end else if (row_cnt >= row_lim) begin
				emit = 1'b1;
				halt_now = 1'b1;
				r.done_res = 1'b1;
			end
		end else if (cur_ofs <= OFS_INODE_3) begin
			ino_acc[8*cur_ofs[1:0] +: 8] = b;
		end else if (cur_ofs == OFS_LEN_LO) begin
			rec_len = {8'd0, b};
		end else if (cur_ofs == OFS_LEN_HI) begin
			rec_len[15:8] = b;
			if (rec_len < MIN_REC_LEN) begin
				emit = 1'b1;
				halt_now = 1'b1;
				r.done_res = 1'b1;
			end
		end else if (cur_ofs == OFS_NAME_LEN) begin
			nm_len = b;
			if (int'(MIN_REC_LEN) + int'(nm_len) > int'(rec_len)) begin
				emit = 1'b1;
				halt_now = 1'b1;
				r.done_res = 1'b1;
			end
		end else if (cur_ofs == OFS_TYPE) begin
			if (ino_acc == 32'd0) begin
				if (final_rec()) begin
					emit = 1'b1;
					halt_now = 1'b1;
					r.done_res = 1'b1;
					r.ok = 1'b1;
				end
			end else if (nm_len == 8'd0) begin
				emit = 1'b1;
				r.entry_inode = ino_acc;
				r.row_end = 1'b1;
				r.done_res = final_rec();
				r.ok = r.done_res;
				halt_now = r.done_res;
				row_cnt++;
			end
		end else if (ino_acc != 32'd0 && int'(cur_ofs) < int'(OFS_NAME) + int'(nm_len)) begin
			emit = 1'b1;
			r.entry_inode = ino_acc;
			r.name_byte = b;
			r.byte_valid = 1'b1;
			r.row_end = (int'(cur_ofs) == int'(OFS_TYPE) + int'(nm_len));
			r.done_res = r.row_end && final_rec();
			r.ok = r.done_res;
			halt_now = r.done_res;
			if (r.row_end)
				row_cnt++;
		end
		if (emit)
			listing_q.push_back(r);
		if (halt_now) begin
			halted = 1'b1;
		end else if (cur_ofs >= OFS_TYPE && int'(cur_ofs) + 1 == int'(rec_len)) begin
			rec_base = rec_base + rec_len;
			cur_ofs = 16'd0;
		end else begin
			cur_ofs = cur_ofs + 16'd1;
		end
	endfunction

	function automatic void check_field(input string nm, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s mismatch: expected %0h, actual %0h", nm, exp_v, got_v);
			fail_cnt++;
		end
	endfunction

	function automatic void queue_byte(input logic [7:0] b, input logic f);
		dir_item_t it;
		it.data = b;
		it.first = f;
		byte_q.push_back(it);
		queued_cnt++;
	endfunction

	function automatic listing_kind_e pick_kind();
		int r;
		r = $urandom_range(0, 9);
		if (r <= 5)
			return LIST_CLEAN;
		return listing_kind_e'(r - 5);
	endfunction

	function automatic void queue_listing(input int dsize, input listing_kind_e kind);
		int          pos;
		int          nlen;
		int          rlen;
		int          pad;
		int          rec;
		int          bad_rec;
		logic [31:0] ino;
		logic [15:0] rl;
		bit          lead;
		pos = 0;
		rec = 0;
		lead = 1'b1;
		bad_rec = $urandom_range(0, 3);
		if (kind == LIST_NOISE)
			repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), 1'b0);
		do begin
			if ($urandom_range(0, 29) == 0)
				nlen = 255;
			else if ($urandom_range(0, 4) == 0)
				nlen = 0;
			else
				nlen = $urandom_range(1, 12);
			ino = ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom);
			pad = $urandom_range(0, 4);
			rlen = 8 + nlen + pad;
			if (pos + rlen >= dsize || $urandom_range(0, 9) == 0) begin
				if (dsize - pos > rlen)
					rlen = dsize - pos;
				if ($urandom_range(0, 3) == 0)
					rlen = rlen + $urandom_range(0, 65535 - rlen);
			end
			if (rec == bad_rec && kind == LIST_SHORT_REC)
				rlen = $urandom_range(0, 7);
			if (rec == bad_rec && kind == LIST_LONG_NAME) begin
				rlen = 8 + $urandom_range(0, 10);
				nlen = rlen - 7 + $urandom_range(0, 3);
			end
			rl = 16'(rlen);
			for (int k = 0; k < 4; k++) begin
				queue_byte(ino[8*k +: 8], lead);
				lead = 1'b0;
			end
			queue_byte(rl[7:0], 1'b0);
			queue_byte(rl[15:8], 1'b0);
			if (rec == bad_rec && kind == LIST_SHORT_REC) begin
				repeat (2) queue_byte(8'($urandom), 1'b0);
				return;
			end
			queue_byte(8'(nlen), 1'b0);
			if (rec == bad_rec && kind == LIST_LONG_NAME) begin
				queue_byte(8'($urandom), 1'b0);
				return;
			end
			queue_byte(8'($urandom), 1'b0);
			repeat (nlen) queue_byte(8'($urandom), 1'b0);
			if (rec == bad_rec && kind == LIST_CUT)
				return;
			pos += rlen;
			if (pos >= dsize && pad > 2)
				pad = 2;
			repeat (pad) queue_byte(8'($urandom), 1'b0);
			rec++;
		end while (pos < dsize);
	endfunction

	task automatic set_reg(input logic [0:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DIR_SIZE)
			size_lim = val;
		else
			row_lim = val[7:0];
	endtask

	task automatic settle();
		do @(negedge clk); while (byte_q.size() != 0 || in_valid || listing_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				step_listing(data_byte, first);
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (byte_q.size() != 0) begin
					nxt_item = byte_q.pop_front();
					in_valid <= 1'b1;
					data_byte <= nxt_item.data;
					first <= nxt_item.first;
					gap_left = tx_burst ? 0 : $urandom_range(0, 4);
					if ($urandom_range(0, 40) == 0)
						tx_burst = !tx_burst;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (listing_q.size() == 0) begin
					$error("unexpected transaction: row_index %0d inode %0h", row_index,
						entry_inode);
					fail_cnt++;
				end else begin
					want = listing_q.pop_front();
					check_field("row_index", 32'(want.row_index), 32'(row_index));
					check_field("entry_inode", want.entry_inode, entry_inode);
					check_field("name_byte", 32'(want.name_byte), 32'(name_byte));
					check_field("byte_valid", 32'(want.byte_valid), 32'(byte_valid));
					check_field("row_end", 32'(want.row_end), 32'(row_end));
					check_field("done_res", 32'(want.done_res), 32'(done_res));
					check_field("ok", 32'(want.ok), 32'(ok));
				end
				res_cnt++;
				stall_left = rx_burst ? 0 : $urandom_range(0, 4);
				if (res_cnt == 300)
					stall_left = 400;
				if ($urandom_range(0, 40) == 0)
					rx_burst = !rx_burst;
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	initial begin
		logic [15:0] dsz;
		logic [7:0]  mrows;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle until first, then an empty directory
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h5A, 1'b1);
		queue_byte(8'hFF, 1'b0);
		settle();

		// live row with a three-byte name, then a dead record closing the directory
		set_reg(REG_DIR_SIZE, 16'd20);
		set_reg(REG_MAX_ROWS, 16'hFFFF);
		queue_byte(8'hFF, 1'b1);
		repeat (3) queue_byte(8'hFF, 1'b0);
		queue_byte(8'h0C, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h03, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h00, 1'b0);
		repeat (4) queue_byte(8'h00, 1'b0);
		queue_byte(8'h08, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h02, 1'b0);
		settle();

		set_reg(REG_DIR_SIZE, 16'hFFFF);
		set_reg(REG_MAX_ROWS, 16'h0000);
		repeat (3) queue_listing(65535, LIST_CLEAN);
		settle();

		set_reg(REG_MAX_ROWS, 16'h0003);
		repeat (4) queue_listing(65535, pick_kind());
		settle();

		while (queued_cnt < 1750) begin
			dsz = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 160));
			case ($urandom_range(0, 3))
				0: mrows = 8'($urandom_range(0, 6));
				1: mrows = 8'($urandom);
				default: mrows = 8'd255;
			endcase
			set_reg(REG_DIR_SIZE, dsz);
			set_reg(REG_MAX_ROWS, {8'($urandom), mrows});
			for (int k = 0; k < 6 && queued_cnt < 1750; k++)
				queue_listing(int'(dsz), pick_kind());
			settle();
		end

		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
